// ===== design/afrg_pkg.sv =====
// ============================================================================
// afrg_pkg
// Shared types and constants for the additive feedback random generator.
// ============================================================================
`default_nettype none

package afrg_pkg;

  localparam int WORD_W          = 32;
  localparam int VALUE_W         = 31;
  localparam int FIELD_IDX_W     = 6;
  localparam int FUNC_W          = 2;
  localparam int CFG_IDX_W       = 2;
  localparam int CFG_DATA_W      = 7;
  localparam int DEGREE_W        = 7;
  localparam int TABLE_DEPTH_DEF = 64;
  localparam int FRONT_RST_POS   = 3;

  localparam logic [DEGREE_W-1:0] DEGREE_RST = 7'd31;

  // LCG constants, low 31 bits are all that matter after masking
  localparam logic [VALUE_W-1:0] LCG_MUL = 31'h41C6_4E6D;
  localparam logic [VALUE_W-1:0] LCG_ADD = 31'd12345;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LCG_MODE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEGREE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SEPARATION = 2'd2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_GEN   = 2'd0,
    FUNC_WRITE = 2'd1,
    FUNC_SET   = 2'd2
  } func_e;

  // broadcast to every table cell
  typedef struct packed {
    logic              gen_add;  // additive step: front cell takes wdata, tokens move
    logic              gen_lcg;  // LCG step: head cell takes wdata
    logic              wr_word;  // table write at the selected cell
    logic              set_pos;  // reload front / rear tokens
    logic [WORD_W-1:0] wdata;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ===== design/afrg_cell.sv =====
// ============================================================================
// afrg_cell
// One table cell: a table word plus the front and rear position tokens.
// ============================================================================
`default_nettype none

module afrg_cell
  import afrg_pkg::*;
#(
  parameter bit FRONT_RST = 1'b0,
  parameter bit REAR_RST  = 1'b0,
  parameter bit HEAD      = 1'b0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctrl_t        ctrl_i,
  input  logic              sel_idx_i,   // index field points here
  input  logic              sel_rear_i,  // rear_index field points here
  input  logic              front_in_i,  // token from the left neighbor / wrap
  input  logic              rear_in_i,
  output logic [WORD_W-1:0] word_o,
  output logic              front_o,
  output logic              rear_o
);

  logic [WORD_W-1:0] word_q;
  logic              front_q, front_d;
  logic              rear_q, rear_d;
  logic              word_we;

  assign word_we = (ctrl_i.wr_word & sel_idx_i) |
                   (ctrl_i.gen_add & front_q) |
                   (ctrl_i.gen_lcg & HEAD);

  always_comb begin
    front_d = front_q;
    rear_d  = rear_q;
    if (ctrl_i.set_pos) begin
      front_d = sel_idx_i;
      rear_d  = sel_rear_i;
    end else if (ctrl_i.gen_add) begin
      front_d = front_in_i;
      rear_d  = rear_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= FRONT_RST;
      rear_q  <= REAR_RST;
    end else begin
      front_q <= front_d;
      rear_q  <= rear_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (word_we) begin
      word_q <= ctrl_i.wdata;
    end
  end

  assign word_o  = word_q;
  assign front_o = front_q;
  assign rear_o  = rear_q;

endmodule

`default_nettype wire

// ===== design/afrg_out_fifo.sv =====
// ============================================================================
// afrg_out_fifo
// Two-entry result buffer: two slots with read and write pointers.
// ============================================================================
`default_nettype none

module afrg_out_fifo
  import afrg_pkg::*;
#(
  parameter int WIDTH = VALUE_W
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [WIDTH-1:0] data_o
);

  logic [WIDTH-1:0] slot_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       cnt_q, cnt_d;
  logic             pop;

  assign pop     = valid_o & ~stall_i;
  assign valid_o = (cnt_q != 2'd0);
  assign full_o  = (cnt_q == 2'd2);
  assign data_o  = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q ^ push_i;
    rd_ptr_d = rd_ptr_q ^ pop;
    cnt_d    = cnt_q;
    if (push_i && !pop) begin
      cnt_d = cnt_q + 2'd1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== design/additive_feedback_random_generator.sv =====
// ============================================================================
// additive_feedback_random_generator
// Additive lagged Fibonacci generator with an LCG fallback mode, built as a
// row of table cells that pass front / rear position tokens along the row.
// ============================================================================
//
//  channel | handshake               | word
//  --------+-------------------------+-------------------------------------
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//  in      | in_valid_i/in_stall_o   | func_i, index_i, word_i, rear_index_i
//  out     | out_valid_o/out_stall_i | value_o
//
//  One input word per cycle while in_stall_o is low. Every operation finishes
//  in the cycle it is accepted: the token hop between cells, the table write
//  and the add (or the LCG multiply) are all one register stage; the value
//  is registered in the result buffer before it shows on the output.
//  Results sit in a two-entry buffer; in_stall_o rises only while both
//  entries are held, so one waiting result never blocks the input.
//  Reset puts the front token in cell 3 and the rear token in cell 0 and
//  clears the result buffer. Table words are not cleared.
//
`default_nettype none

module additive_feedback_random_generator
  import afrg_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]          cfg_index_i,
  input  logic [CFG_DATA_W-1:0]         cfg_data_i,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [FUNC_W-1:0]             func_i,
  input  logic [FIELD_IDX_W-1:0]        index_i,
  input  logic signed [WORD_W-1:0]      word_i,
  input  logic [FIELD_IDX_W-1:0]        rear_index_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [VALUE_W-1:0]            value_o
);

  localparam int POS_W = $clog2(TABLE_DEPTH);
  localparam int DEG_W = $clog2(TABLE_DEPTH + 1);
  localparam int CMP_W = (DEG_W > DEGREE_W) ? DEG_W : DEGREE_W;
  localparam int RED_W = 9;  // holds any field index and any depth up to 256

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                lcg_mode_q;
  logic [DEGREE_W-1:0] degree_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcg_mode_q <= 1'b0;
      degree_q   <= DEGREE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_LCG_MODE:   lcg_mode_q <= cfg_data_i[0];
        CFG_DEGREE:     degree_q   <= cfg_data_i[DEGREE_W-1:0];
        CFG_SEPARATION: ;  // software bookkeeping only, no effect on output
        default:        ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Index reduction modulo table depth (repeated subtract, narrow values)
  // --------------------------------------------------------------------------
  function automatic logic [POS_W-1:0] fold_pos(input logic [FIELD_IDX_W-1:0] v);
    logic [RED_W-1:0] t;
    t = RED_W'(v);
    for (int k = 0; k < 8; k++) begin
      if (t >= RED_W'(TABLE_DEPTH)) begin
        t = t - RED_W'(TABLE_DEPTH);
      end
    end
    return t[POS_W-1:0];
  endfunction

  logic [POS_W-1:0] idx_pos;
  logic [POS_W-1:0] rear_pos;

  assign idx_pos  = fold_pos(index_i);
  assign rear_pos = fold_pos(rear_index_i);

  // effective degree: zero acts as one, anything past the table as the depth
  logic [CMP_W-1:0] deg_x;
  logic [CMP_W-1:0] eff_deg;

  assign deg_x = CMP_W'(degree_q);

  always_comb begin
    if (deg_x == '0) begin
      eff_deg = CMP_W'(1);
    end else if (deg_x > CMP_W'(TABLE_DEPTH)) begin
      eff_deg = CMP_W'(TABLE_DEPTH);
    end else begin
      eff_deg = deg_x;
    end
  end

  // --------------------------------------------------------------------------
  // Handshake and broadcast control
  // --------------------------------------------------------------------------
  logic       fifo_full;
  logic       in_acc;
  logic       gen;
  func_e      func;

  assign in_stall_o = fifo_full;
  assign in_acc     = in_valid_i & ~fifo_full;
  assign func       = func_e'(func_i);

  // --------------------------------------------------------------------------
  // Cell row
  // --------------------------------------------------------------------------
  logic [WORD_W-1:0] cell_word  [TABLE_DEPTH];
  logic              cell_front [TABLE_DEPTH];
  logic              cell_rear  [TABLE_DEPTH];
  logic              front_in   [TABLE_DEPTH];
  logic              rear_in    [TABLE_DEPTH];
  logic              wrap       [TABLE_DEPTH];
  logic              sel_idx    [TABLE_DEPTH];
  logic              sel_rear   [TABLE_DEPTH];
  cell_ctrl_t        ctrl;

  logic [WORD_W-1:0]  front_word, rear_word;
  logic               front_wrap, rear_wrap;
  logic [WORD_W-1:0]  sum;
  logic [VALUE_W-1:0] lcg_prod, lcg_val;

  // a cell whose successor would reach degree sends its token back to cell 0
  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      wrap[i]     = (CMP_W'(i + 1) >= eff_deg);
      sel_idx[i]  = (idx_pos == POS_W'(i));
      sel_rear[i] = (rear_pos == POS_W'(i));
    end
  end

  // one-hot token select of the front and rear words
  always_comb begin
    front_word = '0;
    rear_word  = '0;
    front_wrap = 1'b0;
    rear_wrap  = 1'b0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      front_word = front_word | (cell_word[i] & {WORD_W{cell_front[i]}});
      rear_word  = rear_word  | (cell_word[i] & {WORD_W{cell_rear[i]}});
      front_wrap = front_wrap | (cell_front[i] & wrap[i]);
      rear_wrap  = rear_wrap  | (cell_rear[i] & wrap[i]);
    end
  end

  always_comb begin
    front_in[0] = front_wrap;
    rear_in[0]  = rear_wrap;
    for (int i = 1; i < TABLE_DEPTH; i++) begin
      front_in[i] = cell_front[i-1] & ~wrap[i-1];
      rear_in[i]  = cell_rear[i-1] & ~wrap[i-1];
    end
  end

  assign sum      = front_word + rear_word;
  assign lcg_prod = cell_word[0][VALUE_W-1:0] * LCG_MUL;
  assign lcg_val  = lcg_prod + LCG_ADD;

  always_comb begin
    gen          = in_acc & (func == FUNC_GEN);
    ctrl.gen_add = gen & ~lcg_mode_q;
    ctrl.gen_lcg = gen & lcg_mode_q;
    ctrl.wr_word = in_acc & (func == FUNC_WRITE);
    ctrl.set_pos = in_acc & (func == FUNC_SET);
    // table writes always take the input word, in either mode
    if (func == FUNC_GEN) begin
      if (lcg_mode_q) begin
        ctrl.wdata = {1'b0, lcg_val};
      end else begin
        ctrl.wdata = sum;
      end
    end else begin
      ctrl.wdata = $unsigned(word_i);
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    afrg_cell #(
      .FRONT_RST (g == (FRONT_RST_POS % TABLE_DEPTH)),
      .REAR_RST  (g == 0),
      .HEAD      (g == 0)
    ) u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctrl_i     (ctrl),
      .sel_idx_i  (sel_idx[g]),
      .sel_rear_i (sel_rear[g]),
      .front_in_i (front_in[g]),
      .rear_in_i  (rear_in[g]),
      .word_o     (cell_word[g]),
      .front_o    (cell_front[g]),
      .rear_o     (cell_rear[g])
    );
  end

  // --------------------------------------------------------------------------
  // Result buffer
  // --------------------------------------------------------------------------
  logic [VALUE_W-1:0] gen_value;

  assign gen_value = lcg_mode_q ? lcg_val : sum[WORD_W-1:1];

  afrg_out_fifo #(
    .WIDTH (VALUE_W)
  ) u_out_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (gen),
    .data_i  (gen_value),
    .full_o  (fifo_full),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (value_o)
  );

endmodule

`default_nettype wire

// ===== dv/additive_feedback_random_generator_test.sv =====
// ============================================================================
// additive_feedback_random_generator_test
// Self-checking bench for the additive feedback random generator. A queue of
// pending words feeds a clocked driver; a clocked monitor checks each value
// against a table predictor that steps on every accepted input word.
// ============================================================================
`default_nettype none

module additive_feedback_random_generator_test
  import afrg_pkg::*;
;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = TABLE_DEPTH_DEF;

  // func code with no operation behind it
  localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
  // configuration index with no register behind it
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  localparam logic [WORD_W-1:0] LCG_MULTIPLIER = 32'd1103515245;
  localparam logic [WORD_W-1:0] LCG_INCREMENT  = 32'd12345;
  localparam int unsigned SEPARATION_RST = 3;

  localparam int unsigned CYCLE_LIMIT    = 400_000;
  localparam int unsigned LONG_HOLD      = 400;
  localparam int unsigned DRAIN_CYCLES   = 4;
  localparam int unsigned ITEMS_PER_PASS = 240;
  localparam int unsigned NUM_PASSES     = 8;

  // one input word as the generator sees it
  typedef struct packed {
    logic [FUNC_W-1:0]      func;
    logic [FIELD_IDX_W-1:0] index;
    logic [WORD_W-1:0]      word;
    logic [FIELD_IDX_W-1:0] rear_index;
  } rng_item_t;

  // table contents, which entries hold a defined word, and the two positions
  typedef struct packed {
    logic [TABLE_DEPTH-1:0][WORD_W-1:0] words;
    logic [TABLE_DEPTH-1:0]             written;
    logic [FIELD_IDX_W-1:0]             front;
    logic [FIELD_IDX_W-1:0]             rear;
  } table_state_t;

  // --------------------------------------------------------------------------
  // DUT signals; every input has a known value from time zero
  // --------------------------------------------------------------------------
  logic                   clk_i      = 1'b0;
  logic                   rst_ni     = 1'b0;
  logic                   cfg_valid  = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_data   = '0;
  logic                   in_valid   = 1'b0;
  logic                   in_stall;
  logic [FUNC_W-1:0]      func       = FUNC_GEN;
  logic [FIELD_IDX_W-1:0] index      = '0;
  logic [WORD_W-1:0]      word       = '0;
  logic [FIELD_IDX_W-1:0] rear_index = '0;
  logic                   out_valid;
  logic                   out_stall  = 1'b0;
  logic [VALUE_W-1:0]     value;

  additive_feedback_random_generator #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_o  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .func_i       (func),
    .index_i      (index),
    .word_i       (word),
    .rear_index_i (rear_index),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .value_o      (value)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  // Configuration as last written. It only changes while the block is idle,
  // so the planner and the predictor can share it.
  logic                   cfg_lcg_mode   = 1'b0;
  logic [DEGREE_W-1:0]    cfg_degree     = DEGREE_RST;
  logic [FIELD_IDX_W-1:0] cfg_separation = SEPARATION_RST;

  table_state_t     plan_state;   // state after every queued word
  table_state_t     table_state;  // state after every accepted word
  rng_item_t        pending_items[$];
  logic [VALUE_W-1:0] expected_values[$];

  int unsigned items_queued   = 0;
  int unsigned items_accepted = 0;
  int unsigned errors         = 0;
  int unsigned cycle_count    = 0;
  bit          hold_request   = 1'b0;  // asks the monitor for one long hold
  bit          no_idle        = 1'b0;  // final pass runs at full rate

  task automatic report_mismatch(input string what);
    errors++;
    if (errors <= 100) $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Out-of-range degrees clamp to the table bounds.
  function automatic int unsigned active_degree();
    if (cfg_degree == 0) return 1;
    if (cfg_degree > TABLE_DEPTH) return TABLE_DEPTH;
    return cfg_degree;
  endfunction

  // A position at or past degree is used once, then wraps to zero.
  function automatic logic [FIELD_IDX_W-1:0] next_position(
      input logic [FIELD_IDX_W-1:0] pos, input int unsigned deg);
    int unsigned n;
    n = pos + 1;
    return (n >= deg) ? '0 : n[FIELD_IDX_W-1:0];
  endfunction

  // Steps the generator by one input word; returns 1 when a value results.
  function automatic bit advance_generator(inout table_state_t st,
                                           input rng_item_t it,
                                           output logic [VALUE_W-1:0] rnd);
    logic [WORD_W-1:0] sum;
    int unsigned       deg;
    rnd = '0;
    deg = active_degree();
    case (it.func)
      FUNC_WRITE: begin
        st.words[it.index]   = it.word;
        st.written[it.index] = 1'b1;
        return 1'b0;
      end
      FUNC_SET: begin
        st.front = it.index;
        st.rear  = it.rear_index;
        return 1'b0;
      end
      FUNC_GEN: begin
        if (cfg_lcg_mode) begin
          sum         = st.words[0] * LCG_MULTIPLIER + LCG_INCREMENT;
          rnd         = sum[VALUE_W-1:0];
          st.words[0] = {1'b0, rnd};
        end else begin
          // both reads happen before the write, also when front == rear
          sum                = st.words[st.front] + st.words[st.rear];
          st.words[st.front] = sum;
          rnd                = sum[WORD_W-1:1];
          st.front           = next_position(st.front, deg);
          st.rear            = next_position(st.rear, deg);
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus planning: the planner state tracks what each queued word does,
  // so a generate never reads a table entry that holds no defined word.
  // --------------------------------------------------------------------------
  task automatic queue_item(input logic [FUNC_W-1:0] f,
                            input logic [FIELD_IDX_W-1:0] idx,
                            input logic [WORD_W-1:0] w,
                            input logic [FIELD_IDX_W-1:0] ridx);
    rng_item_t          it;
    logic [VALUE_W-1:0] dont_care;
    it = '{func: f, index: idx, word: w, rear_index: ridx};
    void'(advance_generator(plan_state, it, dont_care));
    pending_items.push_back(it);
    items_queued++;
  endtask

  // Generate, with a write in front for any entry the read would hit unset.
  task automatic queue_gen();
    if (cfg_lcg_mode) begin
      if (!plan_state.written[0]) queue_item(FUNC_WRITE, '0, $urandom, $urandom);
    end else begin
      if (!plan_state.written[plan_state.front])
        queue_item(FUNC_WRITE, plan_state.front, $urandom, $urandom);
      if (!plan_state.written[plan_state.rear])
        queue_item(FUNC_WRITE, plan_state.rear, $urandom, $urandom);
    end
    queue_item(FUNC_GEN, $urandom, $urandom, $urandom);
  endtask

  // Position setup; usually the regular one (front ahead of rear by
  // separation, both below degree), sometimes anywhere in the table.
  task automatic queue_setup();
    int unsigned deg;
    int unsigned fpos;
    int unsigned rpos;
    deg = active_degree();
    if ($urandom_range(0, 3) != 0) begin
      fpos = $urandom_range(0, deg - 1);
      rpos = (fpos + deg - (cfg_separation % deg)) % deg;
    end else begin
      fpos = $urandom_range(0, TABLE_DEPTH - 1);
      rpos = $urandom_range(0, TABLE_DEPTH - 1);
    end
    queue_item(FUNC_SET, fpos, $urandom, rpos);
  endtask

  task automatic fill_random(input int unsigned count);
    int unsigned made;
    int unsigned pick;
    made = 0;
    while (made < count) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        // ignored by the block, does not count
        queue_item(FUNC_UNUSED, $urandom, $urandom, $urandom);
      end else begin
        if (pick < 74) queue_gen();
        else if (pick < 88) queue_item(FUNC_WRITE, $urandom, $urandom, $urandom);
        else queue_setup();
        made++;
      end
    end
  endtask

  // All queued words accepted and all values back, then a short settle.
  task automatic wait_for_drain();
    while (items_accepted != items_queued || expected_values.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    case (idx)
      CFG_LCG_MODE:   cfg_lcg_mode   = data[0];
      CFG_DEGREE:     cfg_degree     = data[DEGREE_W-1:0];
      CFG_SEPARATION: cfg_separation = data[FIELD_IDX_W-1:0];
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Driver: pops pending words, holds a stalled word steady, inserts idle
  // bursts after some accepted words. The predictor steps at acceptance.
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : sender
    rng_item_t          cur_item;
    logic [VALUE_W-1:0] rnd;
    int unsigned        tx_gap;
    if (!rst_ni) begin
      in_valid   <= 1'b0;
      func       <= FUNC_GEN;
      index      <= '0;
      word       <= '0;
      rear_index <= '0;
      tx_gap     = 0;
    end else begin
      if (in_valid && !in_stall) begin
        if (advance_generator(table_state, cur_item, rnd))
          expected_values.push_back(rnd);
        items_accepted++;
      end
      if (!in_valid || !in_stall) begin
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_items.size() != 0) begin
          cur_item   = pending_items.pop_front();
          func       <= cur_item.func;
          index      <= cur_item.index;
          word       <= cur_item.word;
          rear_index <= cur_item.rear_index;
          in_valid   <= 1'b1;
          // gap opens once this word is taken
          if (!no_idle && $urandom_range(0, 11) == 0) tx_gap = $urandom_range(1, 18);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: checks each accepted value against the oldest expectation and
  // drives the output stall (random bursts plus one long hold on request).
  // --------------------------------------------------------------------------
  always @(posedge clk_i or negedge rst_ni) begin : receiver
    logic [VALUE_W-1:0] exp_value;
    logic               stall_next;
    int unsigned        rx_gap;
    int unsigned        hold_left;
    if (!rst_ni) begin
      out_stall <= 1'b0;
      rx_gap    = 0;
      hold_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_values.size() == 0) begin
          report_mismatch($sformatf("value %h with nothing expected", value));
        end else begin
          exp_value = expected_values.pop_front();
          if (value !== exp_value)
            report_mismatch($sformatf("value %h, expected %h", value, exp_value));
        end
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = LONG_HOLD;
      end
      if (hold_left > 0) begin
        hold_left--;
        stall_next = 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        stall_next = 1'b1;
      end else if (!no_idle && $urandom_range(0, 15) == 0) begin
        rx_gap     = $urandom_range(0, 17);
        stall_next = 1'b1;
      end else begin
        stall_next = 1'b0;
      end
      out_stall <= stall_next;
    end
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence: directed words on reset settings, then passes over a range of
  // settings (extremes first), each with random words.
  // --------------------------------------------------------------------------
  initial begin
    logic                   lcg_sel;
    logic [DEGREE_W-1:0]    deg_sel;
    logic [FIELD_IDX_W-1:0] sep_sel;

    plan_state       = '0;
    plan_state.front = FRONT_RST_POS;
    table_state      = plan_state;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // extremes of the word: min + max gives the largest value
    queue_item(FUNC_WRITE, 6'd0, 32'h8000_0000, 6'd0);
    queue_item(FUNC_WRITE, 6'd3, 32'h7FFF_FFFF, 6'd63);
    queue_gen();
    // zero sum gives the smallest value
    queue_item(FUNC_WRITE, 6'd4, 32'h0000_0000, 6'd0);
    queue_item(FUNC_WRITE, 6'd1, 32'h0000_0000, 6'd0);
    queue_gen();
    // unused func with every field bit set
    queue_item(FUNC_UNUSED, 6'd63, 32'hFFFF_FFFF, 6'd63);
    // positions beyond degree at the top of the table: used once, then wrap
    queue_item(FUNC_WRITE, 6'd63, 32'hFFFF_FFFF, 6'd0);
    queue_item(FUNC_WRITE, 6'd62, 32'h1234_5678, 6'd0);
    queue_item(FUNC_SET, 6'd63, 32'h0, 6'd62);
    queue_gen();
    // both positions on the same entry
    queue_gen();
    queue_gen();
    // regular setup just below degree, front wraps before rear
    queue_item(FUNC_WRITE, 6'd30, 32'h5A5A_5A5A, 6'd0);
    queue_item(FUNC_WRITE, 6'd27, 32'hA5A5_A5A5, 6'd0);
    queue_item(FUNC_SET, 6'd30, 32'h0, 6'd27);
    queue_gen();
    queue_gen();
    queue_gen();
    wait_for_drain();

    for (int unsigned pass = 0; pass < NUM_PASSES; pass++) begin
      case (pass)
        0: begin lcg_sel = 1'b0; deg_sel = 7'd1;   sep_sel = 6'd1;  end
        1: begin lcg_sel = 1'b0; deg_sel = 7'd64;  sep_sel = 6'd63; end
        2: begin lcg_sel = 1'b1; deg_sel = 7'd64;  sep_sel = 6'd3;  end
        3: begin lcg_sel = 1'b0; deg_sel = 7'd0;   sep_sel = 6'd5;  end  // clamps to 1
        4: begin lcg_sel = 1'b0; deg_sel = 7'd127; sep_sel = 6'd20; end  // clamps to depth
        5: begin
          lcg_sel = 1'b0;
          deg_sel = $urandom_range(2, TABLE_DEPTH);
          sep_sel = $urandom_range(1, 63);
        end
        6: begin
          lcg_sel = 1'b1;
          deg_sel = $urandom_range(1, 127);
          sep_sel = $urandom_range(1, 63);
        end
        default: begin lcg_sel = 1'b0; deg_sel = 7'd13; sep_sel = 6'd7; end
      endcase
      write_reg(CFG_LCG_MODE, {6'd0, lcg_sel});
      write_reg(CFG_DEGREE, deg_sel);
      write_reg(CFG_SEPARATION, {1'b0, sep_sel});
      if (pass == 0) write_reg(CFG_UNUSED, 7'h7F);
      // long receiver hold so results back up and the input stalls
      if (pass == 1) hold_request = 1'b1;
      if (pass == NUM_PASSES - 1) no_idle = 1'b1;
      fill_random(ITEMS_PER_PASS);
      wait_for_drain();
    end

    repeat (8) @(posedge clk_i);
    if (errors == 0 && expected_values.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
